[hw/rtl/irmst_pkg.sv]
// Shared types and constants for the infrared mark/space transmitter.
package irmst_pkg;

  localparam int IDX_W = 7;
  localparam int REM_W = 15;
  localparam int PRE_W = 10;
  localparam int PH_W  = 16;
  localparam int DUR_W = 16;
  localparam int CFG_W = 16;

  localparam logic [PH_W-1:0]  CARRIER_PERIOD_RST = 16'd1316;
  localparam logic [PRE_W-1:0] TICKS_PER_US_RST   = 10'd50;

  localparam logic CFG_CARRIER_PERIOD = 1'b0;
  localparam logic CFG_TICKS_PER_US   = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_END  = 2'd2
  } req_type_t;

  typedef struct packed {
    logic             ir_out;
    logic             busy_res;
    logic             accepted;
    logic [IDX_W-1:0] segment_count;
  } res_t;

endpackage

[hw/rtl/irmst_if.sv]
// Request and result channel interfaces.
interface irmst_in_if
  import irmst_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [DUR_W-1:0] duration_us;

  modport source (output valid, output req_type, output duration_us, input ready);
  modport sink   (input valid, input req_type, input duration_us, output ready);
endinterface

interface irmst_out_if
  import irmst_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             ir_out;
  logic             busy_res;
  logic             accepted;
  logic [IDX_W-1:0] segment_count;

  modport source (output valid, output ir_out, output busy_res, output accepted,
                  output segment_count, input ready);
  modport sink   (input valid, input ir_out, input busy_res, input accepted,
                  input segment_count, output ready);
endinterface

[hw/rtl/irmst_core.sv]
// Transmitter state, config registers and per-request next-state/result logic.
module irmst_core
  import irmst_pkg::*;
#(
  parameter int MAX_SEGMENTS = 127
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    req_acc,
  input  logic [1:0]              req_type,
  input  logic signed [DUR_W-1:0] duration_us,
  output res_t                    res
);

  logic [PH_W-1:0]  period_r;
  logic [PRE_W-1:0] tpu_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_dec;
  logic [PRE_W-1:0] pre_r, pre_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic             active_r, active_nxt;
  logic [PH_W:0]    ph_inc;
  logic [PRE_W:0]   pre_inc;
  logic             below_limit;
  logic             acc;

  assign below_limit = ({{(32-IDX_W){1'b0}}, idx_r} < 32'(MAX_SEGMENTS));
  assign ph_inc      = {1'b0, phase_r} + {{PH_W{1'b0}}, 1'b1};
  assign pre_inc     = {1'b0, pre_r} + {{PRE_W{1'b0}}, 1'b1};
  assign rem_dec     = rem_r - {{(REM_W-1){1'b0}}, 1'b1};

  always_comb begin
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    pre_nxt    = pre_r;
    phase_nxt  = phase_r;
    active_nxt = active_r;
    acc        = 1'b0;
    case (req_type_t'(req_type))
      REQ_TICK: begin
        phase_nxt = (ph_inc >= {1'b0, period_r}) ? '0 : ph_inc[PH_W-1:0];
        if (active_r) begin
          if (pre_inc >= {1'b0, tpu_r}) begin
            pre_nxt = '0;
            rem_nxt = rem_dec;
            if (rem_dec == '0) begin
              active_nxt = 1'b0;
              idx_nxt    = idx_r + {{(IDX_W-1){1'b0}}, 1'b1};
            end
          end else begin
            pre_nxt = pre_inc[PRE_W-1:0];
          end
        end
      end
      REQ_LOAD: begin
        if (duration_us[DUR_W-1]) begin
          active_nxt = 1'b0;
          rem_nxt    = '0;
          pre_nxt    = '0;
          idx_nxt    = '0;
          acc        = 1'b1;
        end else if (!active_r && below_limit) begin
          acc = 1'b1;
          if (duration_us == '0) begin
            idx_nxt = idx_r + {{(IDX_W-1){1'b0}}, 1'b1};
          end else begin
            rem_nxt    = duration_us[REM_W-1:0];
            pre_nxt    = '0;
            active_nxt = 1'b1;
          end
        end
      end
      REQ_END: begin
        active_nxt = 1'b0;
        rem_nxt    = '0;
        pre_nxt    = '0;
        idx_nxt    = '0;
        acc        = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.ir_out        = active_nxt && !idx_nxt[0] && (phase_nxt < (period_r >> 1));
    res.busy_res      = active_nxt;
    res.accepted      = acc;
    res.segment_count = idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= CARRIER_PERIOD_RST;
      tpu_r    <= TICKS_PER_US_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_CARRIER_PERIOD) period_r <= cfg_wdata[PH_W-1:0];
      if (cfg_idx == CFG_TICKS_PER_US)   tpu_r    <= cfg_wdata[PRE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rem_r    <= '0;
      pre_r    <= '0;
      phase_r  <= '0;
      active_r <= 1'b0;
    end else if (req_acc) begin
      idx_r    <= idx_nxt;
      rem_r    <= rem_nxt;
      pre_r    <= pre_nxt;
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

[hw/rtl/ir_mark_space_transmitter.sv]
// Infrared mark/space transmitter top level.
//
// in_req carries requests: a tick (one step of output waveform), a segment
// load with a signed duration in microseconds, or an end of pattern. Even
// segments are marks (carrier on), odd segments are spaces. Every request
// produces exactly one result on out_res: drive level, busy flag, whether
// the load/end was taken, and the index of the next segment.
// Config (carrier_period, ticks_per_us) is written through cfg_we/cfg_idx/
// cfg_wdata; the user must do it while the block is idle (not enforced).
// The result of each accepted request is registered in the output stage.
// Throughput: one request per cycle while in_req.ready is high; the state
// update is combinational between the state and result registers.
// A two-entry output stage (result register plus skid register) keeps
// in_req.ready high while one result waits; in_req.ready drops only when
// both entries are full, which a stalled result with a request arriving is
// enough to cause, and rises again right after the receiver takes a result.
// Reset clears the pattern state and both output entries and restores the
// config registers to their defaults.
module ir_mark_space_transmitter
  import irmst_pkg::*;
#(
  parameter int MAX_SEGMENTS = 127
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [CFG_W-1:0]   cfg_wdata,
  irmst_in_if.sink           in_req,
  irmst_out_if.source        out_res
);

  res_t res;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic req_acc;

  assign in_req.ready = !skid_valid_r;
  assign req_acc      = in_req.valid && !skid_valid_r;

  irmst_core #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .req_acc     (req_acc),
    .req_type    (in_req.req_type),
    .duration_us (in_req.duration_us),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_res.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= req_acc;
      end
    end else if (req_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_res.ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (req_acc) begin
      skid_r <= res;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.ir_out        = out_r.ir_out;
  assign out_res.busy_res      = out_r.busy_res;
  assign out_res.accepted      = out_r.accepted;
  assign out_res.segment_count = out_r.segment_count;

endmodule

[hw/rtl/irmst_checker.sv]
// Port-level checks for the transmitter, bound to the top level.
module irmst_checker
  import irmst_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             ir_out,
  input logic             busy_res,
  input logic             accepted,
  input logic [IDX_W-1:0] segment_count
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ir_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ir_out) |-> (busy_res && !segment_count[0]))
    else $error("carrier driven outside an active mark");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> out_valid)
    else $error("request stalled with an empty output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(ir_out) && $stable(busy_res) && $stable(accepted) &&
       $stable(segment_count)))
    else $error("stalled result changed");

endmodule

bind ir_mark_space_transmitter irmst_checker u_irmst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .ir_out        (out_res.ir_out),
  .busy_res      (out_res.busy_res),
  .accepted      (out_res.accepted),
  .segment_count (out_res.segment_count)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the infrared mark/space transmitter.
`timescale 1ns / 100ps

module testbench;
  import irmst_pkg::*;

  localparam int SEG_LIMIT = 127;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // per-phase work; one full segment at the slowest rate runs well past it
  localparam int unsigned PHASE_ITEMS = 64;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned RX_HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int PHASE_PERIOD [NUM_PHASES] = '{1316, 2, 0, 1, 9, 65535, 37};
  localparam int PHASE_RATE   [NUM_PHASES] = '{50, 1, 0, 7, 3, 1023, 2};

  class irtx_scoreboard;
    logic [PH_W-1:0]  carrier_period;
    logic [PRE_W-1:0] ticks_per_us;
    logic [IDX_W-1:0] seg_idx;
    logic [REM_W-1:0] remaining_us;
    logic [PRE_W-1:0] us_prescale;
    logic [PH_W-1:0]  carrier_phase;
    bit               seg_active;
    res_t             predicted_res[$];
    int unsigned      errors;

    function void reset_state();
      carrier_period = CARRIER_PERIOD_RST;
      ticks_per_us   = TICKS_PER_US_RST;
      seg_idx        = '0;
      remaining_us   = '0;
      us_prescale    = '0;
      carrier_phase  = '0;
      seg_active     = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_CARRIER_PERIOD) begin
        carrier_period = value;
      end else begin
        ticks_per_us = value[PRE_W-1:0];
      end
    endfunction

    // Returns 1 when the request did something (tick or taken load/end).
    function bit note_request(logic [1:0] req, logic [DUR_W-1:0] dur);
      logic [PH_W:0]  ph;
      logic [PRE_W:0] pre;
      bit             taken;
      res_t           r;
      taken = 1'b0;
      if (req == REQ_TICK) begin
        ph = {1'b0, carrier_phase} + 1'b1;
        if (ph >= {1'b0, carrier_period}) ph = '0;
        carrier_phase = ph[PH_W-1:0];
        if (seg_active) begin
          pre = {1'b0, us_prescale} + 1'b1;
          if (pre >= {1'b0, ticks_per_us}) begin
            pre = '0;
            remaining_us = remaining_us - 1'b1;
            if (remaining_us == '0) begin
              seg_active = 1'b0;
              seg_idx = seg_idx + 1'b1;
            end
          end
          us_prescale = pre[PRE_W-1:0];
        end
      end else if (req == REQ_END || (req == REQ_LOAD && dur[DUR_W-1])) begin
        seg_active   = 1'b0;
        remaining_us = '0;
        us_prescale  = '0;
        seg_idx      = '0;
        taken        = 1'b1;
      end else if (req == REQ_LOAD) begin
        if (!seg_active && seg_idx < SEG_LIMIT) begin
          taken = 1'b1;
          if (dur == '0) begin
            seg_idx = seg_idx + 1'b1;
          end else begin
            remaining_us = dur[REM_W-1:0];
            us_prescale  = '0;
            seg_active   = 1'b1;
          end
        end
      end
      r.ir_out = seg_active && !seg_idx[0] && (carrier_phase < (carrier_period >> 1));
      r.busy_res = seg_active;
      r.accepted = taken;
      r.segment_count = seg_idx;
      predicted_res.push_back(r);
      return (req == REQ_TICK) || taken;
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (predicted_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = predicted_res.pop_front();
      report_field("ir_out", want.ir_out, got.ir_out);
      report_field("busy_res", want.busy_res, got.busy_res);
      report_field("accepted", want.accepted, got.accepted);
      report_field("segment_count", want.segment_count, got.segment_count);
    endfunction

    function int unsigned pending();
      return predicted_res.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  bit               hold_rx = 1'b0;
  bit               no_gaps = 1'b0;
  int unsigned      work_done = 0;
  int unsigned      tx_count = 0;
  irtx_scoreboard   sb;

  irmst_in_if  in_req_if ();
  irmst_out_if out_res_if ();

  ir_mark_space_transmitter #(
    .MAX_SEGMENTS(SEG_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req_if),
    .out_res  (out_res_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    res_t seen;
    if (rst_n === 1'b1) begin
      if (in_req_if.valid === 1'b1 && in_req_if.ready === 1'b1) begin
        if (sb.note_request(in_req_if.req_type, in_req_if.duration_us)) work_done++;
      end
      if (out_res_if.valid === 1'b1 && out_res_if.ready === 1'b1) begin
        seen = {out_res_if.ir_out, out_res_if.busy_res, out_res_if.accepted,
                out_res_if.segment_count};
        sb.check_result(seen);
      end
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [DUR_W-1:0] dur);
    int unsigned gap;
    int unsigned roll;
    in_req_if.valid       <= 1'b1;
    in_req_if.req_type    <= req;
    in_req_if.duration_us <= dur;
    do @(posedge clk); while (in_req_if.ready !== 1'b1);
    tx_count++;
    if (no_gaps || (tx_count / 150) % 3 == 2) begin
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) gap = 0;
      else if (roll < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(input int unsigned period, input int unsigned rate);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CARRIER_PERIOD;
    cfg_wdata <= CFG_W'(period);
    @(posedge clk);
    sb.write_reg(CFG_CARRIER_PERIOD, CFG_W'(period));
    cfg_idx   <= CFG_TICKS_PER_US;
    cfg_wdata <= CFG_W'(rate);
    @(posedge clk);
    sb.write_reg(CFG_TICKS_PER_US, CFG_W'(rate));
    cfg_we <= 1'b0;
  endtask

  // One mark/space pattern: loads with tick runs sized to finish each segment.
  task automatic run_pattern(input int unsigned phase_end, input bit force_long);
    int unsigned      rate;
    int unsigned      max_dur;
    int unsigned      nseg;
    int unsigned      ticks;
    logic [DUR_W-1:0] dur;
    bit               zero_heavy;
    rate = (sb.ticks_per_us == '0) ? 1 : sb.ticks_per_us;
    max_dur = (rate >= 60) ? 1 : 60 / rate;
    zero_heavy = (rate <= 8) && (force_long || $urandom_range(0, 5) == 0);
    nseg = zero_heavy ? $urandom_range(127, 140) : $urandom_range(1, 10);
    for (int i = 0; i < nseg; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: send_req(REQ_UNUSED, DUR_W'($urandom));
          1: send_req(REQ_LOAD, DUR_W'($urandom));
          2: send_req(REQ_END, DUR_W'($urandom));
          default: send_req(REQ_TICK, DUR_W'($urandom));
        endcase
      end
      if (zero_heavy ? $urandom_range(0, 9) != 0 : $urandom_range(0, 3) == 0) begin
        dur = '0;
      end else begin
        dur = DUR_W'($urandom_range(1, zero_heavy ? 1 : max_dur));
      end
      send_req(REQ_LOAD, dur);
      // load while busy, should be dropped
      if (dur != '0 && $urandom_range(0, 9) == 0) begin
        send_req(REQ_LOAD, {1'b0, REM_W'($urandom)});
      end
      ticks = dur * rate;
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(0, ticks)) send_req(REQ_TICK, DUR_W'($urandom));
        send_req(REQ_END, DUR_W'($urandom));
        return;
      end
      if ($urandom_range(0, 3) == 0) ticks += $urandom_range(1, 4);
      repeat (ticks) send_req(REQ_TICK, DUR_W'($urandom));
      if (!zero_heavy && work_done >= phase_end) return;
    end
    if ($urandom_range(0, 3) != 0) send_req(REQ_END, DUR_W'($urandom));
  endtask

  initial begin
    int unsigned rx_cycle;
    int unsigned stall_left;
    rx_cycle = 0;
    stall_left = 0;
    out_res_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_res_if.ready <= 1'b0;
        hold_rx <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        out_res_if.ready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else if ((rx_cycle / 200) % 3 == 1 || $urandom_range(0, 3) != 0) begin
        out_res_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_res_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        @(posedge clk);
      end
      rx_cycle++;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_req_if.valid === 1'b1 && in_req_if.ready === 1'b1) ||
          (out_res_if.valid === 1'b1 && out_res_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned phase_end;
    bit          first;
    sb = new;
    sb.reset_state();
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_CARRIER_PERIOD;
    cfg_wdata             <= '0;
    in_req_if.valid       <= 1'b0;
    in_req_if.req_type    <= REQ_TICK;
    in_req_if.duration_us <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short carrier, one tick per microsecond
    program_config(4, 1);
    send_req(REQ_TICK, 16'h7FFF);
    send_req(REQ_LOAD, 16'd2);
    send_req(REQ_LOAD, 16'd5);
    send_req(REQ_TICK, 16'h8000);
    send_req(REQ_TICK, 16'hFFFF);
    send_req(REQ_LOAD, 16'd0);
    send_req(REQ_LOAD, 16'd1);
    send_req(REQ_TICK, 16'h0000);
    send_req(REQ_UNUSED, 16'hFFFF);
    send_req(REQ_LOAD, 16'h8000);
    send_req(REQ_LOAD, 16'h7FFF);
    send_req(REQ_TICK, 16'h5555);
    send_req(REQ_TICK, 16'hAAAA);
    send_req(REQ_END, 16'h0000);
    send_req(REQ_LOAD, 16'hFFFF);
    send_req(REQ_END, 16'h7FFF);
    send_req(REQ_LOAD, 16'd1);
    send_req(REQ_LOAD, 16'hFFFF);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_config(PHASE_PERIOD[p], PHASE_RATE[p]);
      if (p == 0) begin
        // receiver holds off while requests keep coming
        hold_rx <= 1'b1;
        no_gaps = 1'b1;
        repeat (30) send_req(REQ_TICK, DUR_W'($urandom));
        no_gaps = 1'b0;
      end
      phase_end = work_done + PHASE_ITEMS;
      first = (p == 1);
      while (work_done < phase_end) begin
        run_pattern(phase_end, first);
        first = 1'b0;
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/irmst_pkg.sv
hw/rtl/irmst_if.sv
hw/rtl/irmst_core.sv
hw/rtl/ir_mark_space_transmitter.sv
hw/rtl/irmst_checker.sv
tb/sv/testbench.sv
